[rtl/core/blim_pkg.sv]
// Shared widths, register map, and control/payload types for the bandwidth latency limiter.
package blim_pkg;

  localparam int CYCLE_WIDTH = 48;
  localparam int SIZE_WIDTH  = 16;

  localparam int BPC_W = 8;
  localparam int FIX_W = 8;
  localparam int LAT_W = 32;
  localparam int DUR_W = 16;
  localparam int LIN_W = 16;

  localparam int APB_DW = 32;
  localparam int APB_AW = 4;
  localparam int IDX_W  = 2;

  // Dividend of the ceiling division: byte_count + bytes_per_cycle - 1.
  localparam int NUM_W     = ((SIZE_WIDTH > BPC_W) ? SIZE_WIDTH : BPC_W) + 1;
  localparam int DIV_STEPS = NUM_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam int WAIT_W = (CYCLE_WIDTH > LAT_W) ? CYCLE_WIDTH : LAT_W;
  localparam int DCMP_W = (SIZE_WIDTH > DUR_W) ? SIZE_WIDTH : DUR_W;
  localparam int ADD_W  = (CYCLE_WIDTH > SIZE_WIDTH) ? CYCLE_WIDTH : SIZE_WIDTH;

  localparam logic [LAT_W-1:0] LAT_MAX = '1;
  localparam logic [DUR_W-1:0] DUR_MAX = '1;

  localparam logic [IDX_W-1:0] REG_BPC    = 2'd0;
  localparam logic [IDX_W-1:0] REG_FIXED  = 2'd1;
  localparam logic [IDX_W-1:0] REG_SHARED = 2'd2;

  localparam logic [BPC_W-1:0] BPC_RST = 8'd4;

  typedef struct packed {
    logic [BPC_W-1:0] bytes_per_cycle;
    logic [FIX_W-1:0] fixed_delay;
    logic             shared_read_write;
  } cfg_t;

  typedef struct packed {
    logic [CYCLE_WIDTH-1:0] request_cycle;
    logic [SIZE_WIDTH-1:0]  byte_count;
    logic                   write_op;
    logic [LIN_W-1:0]       latency_so_far;
    logic [DUR_W-1:0]       duration_so_far;
  } req_t;

  typedef struct packed {
    logic [LAT_W-1:0] new_latency;
    logic [DUR_W-1:0] new_duration;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_sts_t;

endpackage

[rtl/core/blim_ifs.sv]
// Valid/ready channel interfaces for requests and results.
interface blim_req_if;
  logic                               valid;
  logic                               ready;
  logic [blim_pkg::CYCLE_WIDTH-1:0]   request_cycle;
  logic [blim_pkg::SIZE_WIDTH-1:0]    byte_count;
  logic                               write_op;
  logic [blim_pkg::LIN_W-1:0]         latency_so_far;
  logic [blim_pkg::DUR_W-1:0]         duration_so_far;

  modport source (output valid, request_cycle, byte_count, write_op, latency_so_far,
                  duration_so_far, input ready);
  modport sink (input valid, request_cycle, byte_count, write_op, latency_so_far,
                duration_so_far, output ready);
endinterface

interface blim_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [blim_pkg::LAT_W-1:0]   new_latency;
  logic [blim_pkg::DUR_W-1:0]   new_duration;

  modport source (output valid, new_latency, new_duration, input ready);
  modport sink (input valid, new_latency, new_duration, output ready);
endinterface

[rtl/core/bandwidth_latency_limiter_top.sv]
// Top level of the bandwidth latency limiter: channels, configuration port and core wiring.
// A request is taken when the block is idle; it then spends one cycle per quotient bit in a
// bit-serial divider (blim_pkg::NUM_W steps, 17 with 16-bit sizes) that forms the burst
// length ceil(byte_count / bytes_per_cycle), then a finish step updates the next-free stamp
// (unless the bandwidth is zero) and loads the result register. The block takes no new
// request until the finish step is done. The result waits in its own register, so the
// next request is taken while the previous result is still unclaimed; the finish step
// stalls only if that register is still full when the next result is ready. The serial
// divider sets the pace of requests, whatever the bandwidth setting, including zero.
module bandwidth_latency_limiter_top (
  input  logic                          clk,
  input  logic                          rst_n,
  blim_req_if.sink                      in_req,
  blim_rsp_if.source                    out_rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [blim_pkg::APB_AW-1:0]   paddr,
  input  logic [blim_pkg::APB_DW-1:0]   pwdata,
  output logic [blim_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  blim_pkg::cfg_t     cfg;
  blim_pkg::req_t     req;
  blim_pkg::rsp_t     rsp;
  blim_pkg::dp_cmd_t  cmd;
  blim_pkg::dp_sts_t  sts;
  logic               in_ready;
  logic               out_valid;

  assign req.request_cycle   = in_req.request_cycle;
  assign req.byte_count      = in_req.byte_count;
  assign req.write_op        = in_req.write_op;
  assign req.latency_so_far  = in_req.latency_so_far;
  assign req.duration_so_far = in_req.duration_so_far;
  assign in_req.ready        = in_ready;

  assign out_rsp.valid        = out_valid;
  assign out_rsp.new_latency  = rsp.new_latency;
  assign out_rsp.new_duration = rsp.new_duration;

  blim_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  blim_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_rsp.ready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  blim_dp u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_i (cfg),
    .req_i (req),
    .cmd_i (cmd),
    .sts_o (sts),
    .rsp_o (rsp)
  );

endmodule

[rtl/core/blim_regs.sv]
// APB configuration registers: bandwidth, fixed delay and shared-stamp mode.
module blim_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [blim_pkg::APB_AW-1:0]   paddr,
  input  logic [blim_pkg::APB_DW-1:0]   pwdata,
  output logic [blim_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output blim_pkg::cfg_t                cfg_o
);

  blim_pkg::cfg_t                 cfg_r, cfg_nxt;
  logic [blim_pkg::IDX_W-1:0]     idx;
  logic                           wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[blim_pkg::APB_AW-1:2];
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg_o  = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        blim_pkg::REG_BPC:    cfg_nxt.bytes_per_cycle   = pwdata[blim_pkg::BPC_W-1:0];
        blim_pkg::REG_FIXED:  cfg_nxt.fixed_delay       = pwdata[blim_pkg::FIX_W-1:0];
        blim_pkg::REG_SHARED: cfg_nxt.shared_read_write = pwdata[0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      blim_pkg::REG_BPC:    prdata = blim_pkg::APB_DW'(cfg_r.bytes_per_cycle);
      blim_pkg::REG_FIXED:  prdata = blim_pkg::APB_DW'(cfg_r.fixed_delay);
      blim_pkg::REG_SHARED: prdata = blim_pkg::APB_DW'(cfg_r.shared_read_write);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bytes_per_cycle   <= blim_pkg::BPC_RST;
      cfg_r.fixed_delay       <= '0;
      cfg_r.shared_read_write <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  a_wr_takes: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && idx == blim_pkg::REG_BPC |=> cfg_r.bytes_per_cycle == $past(pwdata[7:0]))
    else $error("bandwidth register did not take the written value");
  a_no_wr_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !wr_en |=> $stable(cfg_r))
    else $error("configuration changed without a write");
  a_rd_bpc: assert property (@(posedge clk) disable iff (!rst_n)
    idx == blim_pkg::REG_BPC |-> prdata[blim_pkg::BPC_W-1:0] == cfg_r.bytes_per_cycle)
    else $error("bandwidth register reads back wrong");

endmodule

[rtl/core/blim_ctrl.sv]
// Controller: sequences capture, serial division and finish, and owns the result valid.
module blim_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  blim_pkg::dp_sts_t    sts_i,
  output blim_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd_o         = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_o.load = 1'b1;
          state_nxt  = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.step = 1'b1;
        if (sts_i.div_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // The result register may be refilled in the cycle it is being taken.
        if (out_free) begin
          cmd_o.finish  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd_o.load, cmd_o.step, cmd_o.finish}))
    else $error("more than one datapath command at once");
  a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.finish |-> (!out_valid_r || out_ready))
    else $error("result register overwritten before it was taken");
  a_load_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.load |=> state_r == S_DIV)
    else $error("division did not start after a request");
  a_fin_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.finish |=> out_valid_r)
    else $error("finished result not presented");

endmodule

[rtl/core/blim_dp.sv]
// Datapath: request capture, bit-serial ceiling divider, wait and stamp arithmetic.
module blim_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  blim_pkg::cfg_t       cfg_i,
  input  blim_pkg::req_t       req_i,
  input  blim_pkg::dp_cmd_t    cmd_i,
  output blim_pkg::dp_sts_t    sts_o,
  output blim_pkg::rsp_t       rsp_o
);

  blim_pkg::req_t                       req_r;
  logic [blim_pkg::NUM_W-1:0]           num_r, num_nxt;
  logic [blim_pkg::BPC_W-1:0]           rem_r, rem_nxt;
  logic [blim_pkg::CNT_W-1:0]           cnt_r;
  logic [blim_pkg::LAT_W-1:0]           wait_r, wait_nxt;
  logic [blim_pkg::CYCLE_WIDTH-1:0]     start_r, start_nxt;
  logic [blim_pkg::CYCLE_WIDTH-1:0]     rd_stamp_r, wr_stamp_r;
  blim_pkg::rsp_t                       rsp_r, rsp_nxt;

  logic                                 bw_zero;
  logic                                 sel_wr;
  logic [blim_pkg::CYCLE_WIDTH-1:0]     stamp;
  logic [blim_pkg::CYCLE_WIDTH:0]       diff;
  logic [blim_pkg::WAIT_W-1:0]          diff_w;
  logic                                 late;
  logic [blim_pkg::BPC_W:0]             shifted;
  logic                                 fits;
  logic [blim_pkg::SIZE_WIDTH-1:0]      burst;
  logic [blim_pkg::DCMP_W-1:0]          dur_max;
  logic [blim_pkg::LAT_W-1:0]           lat_in;
  logic [blim_pkg::LAT_W-1:0]           lat_base;
  logic [blim_pkg::LAT_W:0]             lat_sum;
  logic [blim_pkg::CYCLE_WIDTH-1:0]     stamp_nxt;

  assign bw_zero = (cfg_i.bytes_per_cycle == '0);
  assign sel_wr  = req_r.write_op | cfg_i.shared_read_write;
  assign stamp   = sel_wr ? wr_stamp_r : rd_stamp_r;

  // Wait until the port is free; the borrow of the subtraction tells whether it is busy.
  assign diff   = {1'b0, stamp} - {1'b0, req_r.request_cycle};
  assign late   = !diff[blim_pkg::CYCLE_WIDTH] && (diff[blim_pkg::CYCLE_WIDTH-1:0] != '0);
  assign diff_w = blim_pkg::WAIT_W'(diff[blim_pkg::CYCLE_WIDTH-1:0]);

  always_comb begin
    if (!late) begin
      wait_nxt = '0;
    end else if (diff_w > blim_pkg::WAIT_W'(blim_pkg::LAT_MAX)) begin
      wait_nxt = blim_pkg::LAT_MAX;
    end else begin
      wait_nxt = blim_pkg::LAT_W'(diff_w);
    end
    start_nxt = late ? stamp : req_r.request_cycle;
  end

  // One quotient bit per step; the quotient shifts into the dividend register.
  assign shifted = {rem_r, num_r[blim_pkg::NUM_W-1]};
  assign fits    = shifted >= {1'b0, cfg_i.bytes_per_cycle};
  assign rem_nxt = fits ? blim_pkg::BPC_W'(shifted - {1'b0, cfg_i.bytes_per_cycle})
                        : shifted[blim_pkg::BPC_W-1:0];
  assign num_nxt = {num_r[blim_pkg::NUM_W-2:0], fits};

  assign sts_o.div_last = (cnt_r == blim_pkg::CNT_W'(blim_pkg::DIV_STEPS - 1));

  assign burst = num_r[blim_pkg::SIZE_WIDTH-1:0];
  assign lat_in = blim_pkg::LAT_W'(req_r.latency_so_far);

  always_comb begin
    if (blim_pkg::DCMP_W'(burst) > blim_pkg::DCMP_W'(req_r.duration_so_far)) begin
      dur_max = blim_pkg::DCMP_W'(burst);
    end else begin
      dur_max = blim_pkg::DCMP_W'(req_r.duration_so_far);
    end

    if (bw_zero || lat_in > wait_r) begin
      lat_base = lat_in;
    end else begin
      lat_base = wait_r;
    end
    lat_sum = {1'b0, lat_base} + (blim_pkg::LAT_W + 1)'(cfg_i.fixed_delay);

    rsp_nxt.new_latency = lat_sum[blim_pkg::LAT_W] ? blim_pkg::LAT_MAX
                                                   : lat_sum[blim_pkg::LAT_W-1:0];
    if (bw_zero) begin
      rsp_nxt.new_duration = req_r.duration_so_far;
    end else if (dur_max > blim_pkg::DCMP_W'(blim_pkg::DUR_MAX)) begin
      rsp_nxt.new_duration = blim_pkg::DUR_MAX;
    end else begin
      rsp_nxt.new_duration = blim_pkg::DUR_W'(dur_max);
    end

    stamp_nxt = blim_pkg::CYCLE_WIDTH'(blim_pkg::ADD_W'(start_r) + blim_pkg::ADD_W'(burst));
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      req_r <= req_i;
      num_r <= blim_pkg::NUM_W'(req_i.byte_count) + blim_pkg::NUM_W'(cfg_i.bytes_per_cycle)
               - blim_pkg::NUM_W'(1);
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd_i.step) begin
      num_r   <= num_nxt;
      rem_r   <= rem_nxt;
      cnt_r   <= cnt_r + blim_pkg::CNT_W'(1);
      wait_r  <= wait_nxt;
      start_r <= start_nxt;
    end
    if (cmd_i.finish) begin
      rsp_r <= rsp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_stamp_r <= '0;
      wr_stamp_r <= '0;
    end else if (cmd_i.finish && !bw_zero) begin
      if (sel_wr) begin
        wr_stamp_r <= stamp_nxt;
      end else begin
        rd_stamp_r <= stamp_nxt;
      end
    end
  end

  assign rsp_o = rsp_r;

  a_cnt_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.load |=> cnt_r == '0)
    else $error("divider step count not cleared on a new request");
  a_zero_bw_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.finish && bw_zero |=> $stable(rd_stamp_r) && $stable(wr_stamp_r))
    else $error("stamp moved with limiting disabled");
  a_dur_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.finish |=> rsp_r.new_duration >= req_r.duration_so_far)
    else $error("duration below the incoming duration");
  a_lat_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.finish |=> rsp_r.new_latency >= blim_pkg::LAT_W'(req_r.latency_so_far))
    else $error("latency below the incoming latency");

endmodule

[verif/bandwidth_latency_limiter_checker.sv]
// Passive checker for the bandwidth latency limiter: predicts each result and compares it.
module bandwidth_latency_limiter_checker
  import blim_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  blim_req_if               req_ch,
  blim_rsp_if               rsp_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  input  logic              pready,
  output int                mismatches,
  output int                outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  cfg_t                   limits;
  logic [CYCLE_WIDTH-1:0] read_free;
  logic [CYCLE_WIDTH-1:0] write_free;
  rsp_t                   due_responses[$];
  int                     bad_count = 0;

  function automatic logic [63:0] clamp_latency(input logic [63:0] v);
    return (v > 64'(LAT_MAX)) ? 64'(LAT_MAX) : v;
  endfunction

  // Works out the result of one request and advances the next-free stamps.
  function automatic rsp_t limit_request(input req_t r);
    logic [63:0] cyc;
    logic [63:0] stamp;
    logic [63:0] wait_cycles;
    logic [63:0] burst;
    logic [63:0] lat;
    logic [63:0] dur;
    logic        on_write_stamp;
    rsp_t        res;
    cyc = 64'(r.request_cycle);
    if (limits.bytes_per_cycle != '0) begin
      burst = (64'(r.byte_count) + 64'(limits.bytes_per_cycle) - 64'd1)
              / 64'(limits.bytes_per_cycle);
      on_write_stamp = r.write_op || limits.shared_read_write;
      stamp = on_write_stamp ? 64'(write_free) : 64'(read_free);
      wait_cycles = (stamp > cyc) ? clamp_latency(stamp - cyc) : 64'd0;
      lat = (wait_cycles > 64'(r.latency_so_far)) ? wait_cycles : 64'(r.latency_so_far);
      lat = clamp_latency(lat + 64'(limits.fixed_delay));
      dur = (burst > 64'(r.duration_so_far)) ? burst : 64'(r.duration_so_far);
      if (dur > 64'(DUR_MAX)) begin
        dur = 64'(DUR_MAX);
      end
      stamp = ((stamp > cyc) ? stamp : cyc) + burst;
      if (on_write_stamp) begin
        write_free = stamp[CYCLE_WIDTH-1:0];
      end else begin
        read_free = stamp[CYCLE_WIDTH-1:0];
      end
    end else begin
      lat = clamp_latency(64'(r.latency_so_far) + 64'(limits.fixed_delay));
      dur = 64'(r.duration_so_far);
    end
    res.new_latency  = lat[LAT_W-1:0];
    res.new_duration = dur[DUR_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    req_t seen;
    rsp_t want;
    if (!rst_n) begin
      limits.bytes_per_cycle   = BPC_RST;
      limits.fixed_delay       = '0;
      limits.shared_read_write = 1'b1;
      read_free  = '0;
      write_free = '0;
      due_responses.delete();
    end else begin
      // The registers only change while no request is in flight.
      if (psel && penable && pwrite && pready) begin
        case (paddr[APB_AW-1:2])
          REG_BPC: begin
            limits.bytes_per_cycle = pwdata[BPC_W-1:0];
          end
          REG_FIXED: begin
            limits.fixed_delay = pwdata[FIX_W-1:0];
          end
          REG_SHARED: begin
            limits.shared_read_write = pwdata[0];
          end
          default: ;
        endcase
      end
      if (req_ch.valid && req_ch.ready) begin
        seen.request_cycle   = req_ch.request_cycle;
        seen.byte_count      = req_ch.byte_count;
        seen.write_op        = req_ch.write_op;
        seen.latency_so_far  = req_ch.latency_so_far;
        seen.duration_so_far = req_ch.duration_so_far;
        due_responses.insert(due_responses.size(), limit_request(seen));
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (due_responses.size() == 0) begin
          bad_count++;
          if (bad_count <= REPORT_LIMIT) begin
            $display("%0t: result with no request pending: latency %h duration %h",
                     $realtime, rsp_ch.new_latency, rsp_ch.new_duration);
          end
        end else begin
          want = due_responses.pop_front();
          if (rsp_ch.new_latency !== want.new_latency ||
              rsp_ch.new_duration !== want.new_duration) begin
            bad_count++;
            if (bad_count <= REPORT_LIMIT) begin
              $display("%0t: result mismatch: latency exp %h got %h, duration exp %h got %h",
                       $realtime, want.new_latency, rsp_ch.new_latency,
                       want.new_duration, rsp_ch.new_duration);
            end
          end
        end
      end
    end
    mismatches  <= bad_count;
    outstanding <= due_responses.size();
  end

endmodule

[verif/bandwidth_latency_limiter_top_tb.sv]
// Testbench top for the bandwidth latency limiter: clock, reset, stimulus and verdict.
module bandwidth_latency_limiter_top_tb;
  import blim_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [IDX_W-1:0] REG_NONE = 2'd3;
  localparam int MAX_GAP         = 18;
  localparam int RAND_PHASES     = 8;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int HOLD_AT         = 350;
  localparam int HOLD_CYCLES     = 400;
  localparam int DRAIN_CYCLES    = 40;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  logic rx_ready = 1'b0;
  logic rx_hold = 1'b0;
  logic tx_steady = 1'b0;
  logic rx_steady = 1'b0;
  int   reqs_sent = 0;
  int   mismatches;
  int   outstanding;

  logic [CYCLE_WIDTH-1:0] now_cycle = '0;

  blim_req_if req_ch ();
  blim_rsp_if rsp_ch ();

  assign rsp_ch.ready = rx_ready && !rx_hold;

  initial begin
    req_ch.valid           = 1'b0;
    req_ch.request_cycle   = '0;
    req_ch.byte_count      = '0;
    req_ch.write_op        = 1'b0;
    req_ch.latency_so_far  = '0;
    req_ch.duration_so_far = '0;
  end

  bandwidth_latency_limiter_top uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bandwidth_latency_limiter_checker limiter_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_ch      (req_ch),
    .rsp_ch      (rsp_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #5ns clk = ~clk;

  function automatic req_t make_request(input logic [CYCLE_WIDTH-1:0] cyc,
                                        input logic [SIZE_WIDTH-1:0] size,
                                        input logic wr,
                                        input logic [LIN_W-1:0] lat,
                                        input logic [DUR_W-1:0] dur);
    req_t r;
    r.request_cycle   = cyc;
    r.byte_count      = size;
    r.write_op        = wr;
    r.latency_so_far  = lat;
    r.duration_so_far = dur;
    return r;
  endfunction

  // Mostly a steadily advancing cycle stamp with small bursts, so the ports back up;
  // the rest jumps around, runs near the stamp wrap, or reuses a stale stamp.
  function automatic req_t next_random_request();
    req_t r;
    int   pick;
    pick = $urandom_range(0, 99);
    r.write_op        = 1'($urandom);
    r.byte_count      = 16'($urandom_range(0, 256));
    r.latency_so_far  = 16'($urandom_range(0, 64));
    r.duration_so_far = 16'($urandom_range(0, 64));
    if (pick < 70) begin
      now_cycle += CYCLE_WIDTH'($urandom_range(0, 24));
    end else if (pick < 82) begin
      now_cycle += CYCLE_WIDTH'($urandom_range(0, 24));
      r.byte_count      = 16'($urandom);
      r.latency_so_far  = 16'($urandom);
      r.duration_so_far = 16'($urandom);
    end else if (pick < 88) begin
      now_cycle = CYCLE_WIDTH'({$urandom, $urandom});
    end else if (pick < 94) begin
      now_cycle = '1 - CYCLE_WIDTH'($urandom_range(0, 3000));
    end
    r.request_cycle = now_cycle;
    if (pick >= 94) begin
      r.request_cycle = now_cycle - CYCLE_WIDTH'($urandom_range(0, 5000));
    end
    return r;
  endfunction

  task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_limits(input logic [BPC_W-1:0] bpc, input logic [FIX_W-1:0] fixed,
                            input logic shared);
    cfg_write(REG_BPC, APB_DW'(bpc));
    cfg_write(REG_FIXED, APB_DW'(fixed));
    cfg_write(REG_SHARED, APB_DW'(shared));
  endtask

  task automatic offer_request(input req_t r);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid           <= 1'b1;
    req_ch.request_cycle   <= r.request_cycle;
    req_ch.byte_count      <= r.byte_count;
    req_ch.write_op        <= r.write_op;
    req_ch.latency_so_far  <= r.latency_so_far;
    req_ch.duration_so_far <= r.duration_so_far;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    reqs_sent++;
    if ($urandom_range(0, 39) == 0) begin
      tx_steady = !tx_steady;
    end
  endtask

  // Stops offering and waits until every request has its result back.
  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Result side: random stalls per result, with stretches of none.
  initial begin
    int gap;
    forever begin
      gap = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        rx_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rx_ready <= 1'b1;
      @(posedge clk);
      while (!(rsp_ch.valid && rsp_ch.ready)) @(posedge clk);
      if ($urandom_range(0, 39) == 0) begin
        rx_steady = !rx_steady;
      end
    end
  end

  // One long result stall in the middle of a random phase fills the block up.
  initial begin
    wait (reqs_sent >= HOLD_AT);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [BPC_W-1:0] bpc;
    logic [FIX_W-1:0] fixed;
    logic             shared;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: shared stamp, four bytes per cycle, no fixed delay.
    offer_request(make_request(48'd0, 16'd0, 1'b0, 16'd0, 16'd0));
    offer_request(make_request(48'd100, 16'hFFFF, 1'b1, 16'hFFFF, 16'd0));
    offer_request(make_request(48'd101, 16'd1, 1'b0, 16'd0, 16'hFFFF));
    offer_request(make_request(48'hFFFF_FFFF_FFFF, 16'd3, 1'b1, 16'h5555, 16'hAAAA));
    offer_request(make_request(48'hAAAA_AAAA_AAAA, 16'hAAAA, 1'b0, 16'hAAAA, 16'h5555));
    offer_request(make_request(48'h5555_5555_5555, 16'h5555, 1'b1, 16'h0001, 16'h0000));
    settle();

    // Separate stamps, one byte per cycle, largest fixed delay; the write to the
    // unused register index must change nothing.
    set_limits(8'd1, 8'd255, 1'b0);
    cfg_write(REG_NONE, '1);
    offer_request(make_request(48'h1_0000_0000, 16'd16, 1'b1, 16'd0, 16'd0));
    offer_request(make_request(48'h1_0000_0000, 16'd8, 1'b0, 16'd0, 16'd0));
    // Wait just under 32 bits, then one beyond it: both saturate the latency.
    offer_request(make_request(48'h20, 16'd4, 1'b1, 16'd0, 16'd0));
    offer_request(make_request(48'h0, 16'd1, 1'b1, 16'd7, 16'd0));
    // The read stamp wraps past the top of the cycle range.
    offer_request(make_request(48'hFFFF_FFFF_FFFC, 16'd100, 1'b0, 16'd0, 16'd0));
    offer_request(make_request(48'd10, 16'd1, 1'b0, 16'd0, 16'd0));
    settle();

    // Zero bandwidth only adds the fixed delay.
    set_limits(8'd0, 8'd255, 1'b1);
    offer_request(make_request(48'd5, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF));
    offer_request(make_request(48'd0, 16'd0, 1'b0, 16'd0, 16'd0));
    settle();

    set_limits(8'd255, 8'd0, 1'b1);
    offer_request(make_request(48'd1000, 16'hFFFF, 1'b1, 16'd0, 16'd0));
    offer_request(make_request(48'd1000, 16'd255, 1'b0, 16'd0, 16'd0));
    offer_request(make_request(48'd1001, 16'd256, 1'b0, 16'd0, 16'd0));
    offer_request(make_request(48'd2000, 16'd0, 1'b1, 16'd0, 16'd1));
    settle();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case ($urandom_range(0, 5))
        0: bpc = 8'd0;
        1: bpc = 8'd1;
        2: bpc = 8'd255;
        3: bpc = BPC_RST;
        default: bpc = 8'($urandom_range(1, 255));
      endcase
      case ($urandom_range(0, 2))
        0: fixed = 8'd0;
        1: fixed = 8'd255;
        default: fixed = 8'($urandom);
      endcase
      shared = 1'($urandom);
      set_limits(bpc, fixed, shared);
      repeat (ITEMS_PER_PHASE) offer_request(next_random_request());
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
